// ===== rtl/multichannel_periodic_timer_assert.svh =====
// Assertion macros for the periodic timer checker.
`ifndef MULTICHANNEL_PERIODIC_TIMER_ASSERT_SVH
`define MULTICHANNEL_PERIODIC_TIMER_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define MPT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define MPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MPT_ASSERT_CLK(lbl, ante |-> cons, msg)

// Next-cycle implication.
`define MPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MPT_ASSERT_CLK(lbl, ante |=> cons, msg)

`endif

// ===== rtl/mpt_pkg.sv =====
// Shared types and constants for the multichannel periodic timer.
`timescale 1ns / 1ps

package mpt_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int SEL_W        = 3;
  localparam int CH_W         = 2;
  localparam int FLAGS_W      = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_STATUS = 3'd0,
    SEL_MASK   = 3'd1,
    SEL_RELOAD = 3'd2,
    SEL_ENABLE = 3'd3,
    SEL_COUNT  = 3'd4
  } sel_t;

  typedef struct packed {
    logic              tick;
    logic              wr_reload;
    logic              wr_enable;
    logic [DATA_W-1:0] wdata;
  } mpt_chan_ctl_t;

  typedef struct packed {
    logic              enabled;
    logic              expire;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] reload;
  } mpt_chan_sts_t;

endpackage

// ===== rtl/mpt_chan.sv =====
// One timer channel: reload register, down-counter and enable.
`timescale 1ns / 1ps

module mpt_chan
  import mpt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  mpt_chan_ctl_t ctl,
  output mpt_chan_sts_t sts
);

  logic [DATA_W-1:0] counter_r, counter_nxt;
  logic [DATA_W-1:0] reload_r, reload_nxt;
  logic              en_r, en_nxt;
  logic              expire;

  always_comb begin
    counter_nxt = counter_r;
    reload_nxt  = reload_r;
    en_nxt      = en_r;
    expire      = 1'b0;
    if (ctl.tick && en_r) begin
      if (counter_r == '0) begin
        counter_nxt = reload_r;
        expire      = 1'b1;
      end else begin
        counter_nxt = counter_r - DATA_W'(1);
      end
    end
    if (ctl.wr_reload) begin
      reload_nxt = ctl.wdata;
    end
    if (ctl.wr_enable) begin
      if (ctl.wdata[0]) begin
        if (!en_r) begin
          counter_nxt = reload_r;
        end
        en_nxt = 1'b1;
      end else begin
        en_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      reload_r  <= '0;
      en_r      <= 1'b0;
    end else begin
      counter_r <= counter_nxt;
      reload_r  <= reload_nxt;
      en_r      <= en_nxt;
    end
  end

  assign sts.enabled = en_r;
  assign sts.expire  = expire;
  assign sts.count   = counter_r;
  assign sts.reload  = reload_r;

endmodule

// ===== rtl/multichannel_periodic_timer.sv =====
// Top level of the multichannel periodic timer.
//
//   port group   direction  handshake            payload
//   in_          request    in_valid / in_stall  req_type, reg_sel, channel, write_data
//   out_         result     out_valid/out_stall  read_data, timeout_flags, irq
//   cfg_         write      cfg_we               cfg_wdata (module enable)
//
// One request per cycle sustained while the output does not stall; the request register
// feeds the channel counters and decode, whose result lands in the output register when
// the request advances. A stalled output holds the request register and raises in_stall.
// Synchronous reset clears counters, reloads, enables, flags, mask and module enable.
`timescale 1ns / 1ps

module multichannel_periodic_timer
  import mpt_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [SEL_W-1:0]   in_reg_sel,
  input  logic [CH_W-1:0]    in_channel,
  input  logic [DATA_W-1:0]  in_write_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_read_data,
  output logic [FLAGS_W-1:0] out_timeout_flags,
  output logic               out_irq,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic               s1_vld_r;
  logic [REQ_W-1:0]   s1_req_r;
  logic [SEL_W-1:0]   s1_sel_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic [DATA_W-1:0]  s1_wdata_r;
  logic               out_vld_r;
  logic [DATA_W-1:0]  out_rd_r;
  logic [FLAGS_W-1:0] out_tf_r;
  logic               out_irq_r;
  logic               mod_en_r;
  logic [CHANNELS-1:0] flags_r, flags_nxt;
  logic [CHANNELS-1:0] mask_r, mask_nxt;

  logic                adv;
  logic                accept;
  logic                tick_go;
  logic                wr_go;
  logic [CHANNELS-1:0] ch_hit;
  logic [CHANNELS-1:0] expire_vec;
  logic [CHANNELS-1:0] clr;
  logic [DATA_W-1:0]   rd;
  logic [DATA_W-1:0]   cnt_mux;
  logic [DATA_W-1:0]   rel_mux;
  logic                en_mux;
  logic [FLAGS_W+CHANNELS-1:0] flags_ext;

  mpt_chan_ctl_t ctl [CHANNELS];
  mpt_chan_sts_t sts [CHANNELS];

  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign accept   = in_valid && !in_stall;

  assign tick_go = adv && (s1_req_r == REQ_TICK) && mod_en_r;
  assign wr_go   = adv && (s1_req_r == REQ_WRITE);

  for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
    assign ch_hit[n]         = (int'(s1_ch_r) == n);
    assign ctl[n].tick       = tick_go;
    assign ctl[n].wr_reload  = wr_go && (s1_sel_r == SEL_RELOAD) && ch_hit[n];
    assign ctl[n].wr_enable  = wr_go && (s1_sel_r == SEL_ENABLE) && ch_hit[n];
    assign ctl[n].wdata      = s1_wdata_r;
    assign expire_vec[n]     = sts[n].expire;

    mpt_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[n]),
      .sts   (sts[n])
    );
  end

  always_comb begin
    clr       = (wr_go && (s1_sel_r == SEL_STATUS)) ? s1_wdata_r[CHANNELS-1:0] : '0;
    flags_nxt = (flags_r & ~clr) | expire_vec;
    mask_nxt  = (wr_go && (s1_sel_r == SEL_MASK)) ? s1_wdata_r[CHANNELS-1:0] : mask_r;
    flags_ext = {{FLAGS_W{1'b0}}, flags_nxt};
  end

  always_comb begin
    cnt_mux = '0;
    rel_mux = '0;
    en_mux  = 1'b0;
    for (int n = 0; n < CHANNELS; n++) begin
      if (ch_hit[n]) begin
        cnt_mux = sts[n].count;
        rel_mux = sts[n].reload;
        en_mux  = sts[n].enabled;
      end
    end
  end

  always_comb begin
    rd = '0;
    if (s1_req_r == REQ_READ) begin
      unique case (s1_sel_r)
        SEL_STATUS: rd = DATA_W'(flags_r);
        SEL_MASK:   rd = DATA_W'(mask_r);
        SEL_RELOAD: rd = rel_mux;
        SEL_ENABLE: rd = DATA_W'(en_mux);
        SEL_COUNT:  rd = cnt_mux;
        default:    rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mod_en_r  <= 1'b0;
      flags_r   <= '0;
      mask_r    <= '0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        mod_en_r <= cfg_wdata;
      end
      flags_r <= flags_nxt;
      mask_r  <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r   <= in_req_type;
      s1_sel_r   <= in_reg_sel;
      s1_ch_r    <= in_channel;
      s1_wdata_r <= in_write_data;
    end
    if (adv) begin
      out_rd_r  <= rd;
      out_tf_r  <= flags_ext[FLAGS_W-1:0];
      out_irq_r <= |(flags_nxt & mask_nxt);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_read_data     = out_rd_r;
  assign out_timeout_flags = out_tf_r;
  assign out_irq           = out_irq_r;

endmodule

// ===== rtl/mpt_checker.sv =====
// Port-level assertions for the multichannel periodic timer, with bind.
`timescale 1ns / 1ps
`include "multichannel_periodic_timer_assert.svh"

module mpt_checker
  import mpt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DATA_W-1:0]  out_read_data,
  input logic [FLAGS_W-1:0] out_timeout_flags,
  input logic               out_irq
);

  // request side only backs up behind a stalled result
  `MPT_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without output stall")

  // interrupt needs a raised flag
  `MPT_ASSERT_IMPL(a_irq_flag, out_valid && out_irq, out_timeout_flags != '0, "irq with no flag set")

  // stalled result holds
  `MPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_data) && $stable(out_timeout_flags) && $stable(out_irq), "stalled result changed")

  // a request waits at most behind one held result
  `MPT_ASSERT_NEXT(a_in_release, in_stall && !out_stall, !in_stall, "in_stall outlived output stall")

endmodule

bind multichannel_periodic_timer mpt_checker u_mpt_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the four-channel periodic timer: bus requests in, register results out.
`timescale 1ns / 1ps

module tb_top;
  import mpt_pkg::*;

  localparam int               NCH         = CHANNELS_DEF;
  localparam int               LAT_CYC     = 4;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [SEL_W-1:0]  sel;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] data;
  } bus_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  rdata;
    logic [FLAGS_W-1:0] flags;
    logic               irq;
  } bus_resp_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   in_req_type   = '0;
  logic [SEL_W-1:0]   in_reg_sel    = '0;
  logic [CH_W-1:0]    in_channel    = '0;
  logic [DATA_W-1:0]  in_write_data = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [DATA_W-1:0]  out_read_data;
  logic [FLAGS_W-1:0] out_timeout_flags;
  logic               out_irq;
  logic               cfg_we        = 1'b0;
  logic               cfg_wdata     = 1'b0;

  multichannel_periodic_timer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_reg_sel       (in_reg_sel),
    .in_channel       (in_channel),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_timeout_flags(out_timeout_flags),
    .out_irq          (out_irq),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timer state as the predictor sees it
  logic [DATA_W-1:0]  tm_reload [NCH];
  logic [DATA_W-1:0]  tm_count  [NCH];
  logic               tm_en     [NCH];
  logic [FLAGS_W-1:0] tm_flags;
  logic [FLAGS_W-1:0] tm_mask;
  logic               tm_module_en;

  bus_req_t  bus_req_q[$];
  bus_resp_t bus_resp_q[$];
  int        err_cnt = 0;

  initial begin
    for (int n = 0; n < NCH; n++) begin
      tm_reload[n] = '0;
      tm_count[n]  = '0;
      tm_en[n]     = 1'b0;
    end
    tm_flags     = '0;
    tm_mask      = '0;
    tm_module_en = 1'b0;
  end

  function automatic bus_resp_t timer_respond(bus_req_t r);
    bus_resp_t res;
    int        n;
    res.rdata = '0;
    case (r.req)
      REQ_TICK: begin
        if (tm_module_en) begin
          for (n = 0; n < NCH; n++) begin
            if (tm_en[n]) begin
              if (tm_count[n] == '0) begin
                tm_count[n] = tm_reload[n];
                tm_flags[n] = 1'b1;
              end else begin
                tm_count[n] = tm_count[n] - 1'b1;
              end
            end
          end
        end
      end
      REQ_WRITE: begin
        case (r.sel)
          SEL_STATUS: tm_flags = tm_flags & ~r.data[FLAGS_W-1:0];
          SEL_MASK:   tm_mask  = r.data[FLAGS_W-1:0];
          SEL_RELOAD: tm_reload[r.ch] = r.data;
          SEL_ENABLE: begin
            if (r.data[0]) begin
              if (!tm_en[r.ch]) tm_count[r.ch] = tm_reload[r.ch];
              tm_en[r.ch] = 1'b1;
            end else begin
              tm_en[r.ch] = 1'b0;
            end
          end
          default: ;
        endcase
      end
      REQ_READ: begin
        case (r.sel)
          SEL_STATUS: res.rdata = DATA_W'(tm_flags);
          SEL_MASK:   res.rdata = DATA_W'(tm_mask);
          SEL_RELOAD: res.rdata = tm_reload[r.ch];
          SEL_ENABLE: res.rdata = DATA_W'(tm_en[r.ch]);
          SEL_COUNT:  res.rdata = tm_count[r.ch];
          default:    res.rdata = '0;
        endcase
      end
      default: ;
    endcase
    res.flags = tm_flags;
    res.irq   = |(tm_flags & tm_mask);
    return res;
  endfunction

  // mostly sensible register traffic with small reloads so channels expire often
  function automatic bus_req_t rand_req();
    bus_req_t r;
    int       pick;
    r.req  = REQ_TICK;
    r.sel  = SEL_W'($urandom_range(0, 7));
    r.ch   = CH_W'($urandom_range(0, 3));
    r.data = $urandom;
    pick   = $urandom_range(0, 99);
    if (pick < 50) begin
      r.req = REQ_TICK;
    end else if (pick < 75) begin
      r.req = REQ_WRITE;
      pick  = $urandom_range(0, 99);
      if (pick < 30) begin
        r.sel = SEL_RELOAD;
        if ($urandom_range(0, 9) != 0) r.data = DATA_W'($urandom_range(0, 6));
      end else if (pick < 50) begin
        r.sel = SEL_ENABLE;
        if ($urandom_range(0, 3) != 0) r.data[0] = 1'b1;
      end else if (pick < 65) begin
        r.sel = SEL_STATUS;
      end else if (pick < 80) begin
        r.sel = SEL_MASK;
      end
    end else if (pick < 96) begin
      r.req = REQ_READ;
      if ($urandom_range(0, 3) != 0) r.sel = SEL_W'($urandom_range(0, 4));
    end else begin
      r.req = REQ_UNKNOWN;
    end
    return r;
  endfunction

  task automatic push_req(logic [REQ_W-1:0] req, logic [SEL_W-1:0] sel,
                          logic [CH_W-1:0] ch, logic [DATA_W-1:0] data);
    bus_req_t r;
    r.req  = req;
    r.sel  = sel;
    r.ch   = ch;
    r.data = data;
    bus_req_q.push_back(r);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) bus_req_q.push_back(rand_req());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bus_req_q.size() != 0 || in_valid || bus_resp_q.size() != 0);
    repeat (LAT_CYC) @(negedge clk);
  endtask

  task automatic set_module_en(logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    tm_module_en  = v;
  endtask

  // driver: bursts of requests with random gaps
  bus_req_t cur_req;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) bus_resp_q.push_back(timer_respond(cur_req));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bus_req_q.size() != 0) begin
          cur_req        = bus_req_q.pop_front();
          in_req_type   <= cur_req.req;
          in_reg_sel    <= cur_req.sel;
          in_channel    <= cur_req.ch;
          in_write_data <= cur_req.data;
          in_valid      <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result stall pattern and field checks
  int   stall_cyc = 0;
  int   stall_run = 0;
  logic stall_on  = 1'b0;

  always @(posedge clk) begin
    stall_cyc++;
    case ((stall_cyc / 97) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 16);
          stall_on  = ~stall_on;
        end
        stall_run--;
        out_stall <= stall_on;
      end
      default: out_stall <= stall_cyc[0];
    endcase

    if (rst_n && out_valid && !out_stall) begin
      if (bus_resp_q.size() == 0) begin
        $display("%0t: unexpected result expected none got rd=%h flags=%h irq=%b",
                 $time, out_read_data, out_timeout_flags, out_irq);
        err_cnt++;
      end else begin
        bus_resp_t e;
        e = bus_resp_q.pop_front();
        if (out_read_data !== e.rdata) begin
          $display("%0t: read_data expected %h got %h", $time, e.rdata, out_read_data);
          err_cnt++;
        end
        if (out_timeout_flags !== e.flags) begin
          $display("%0t: timeout_flags expected %h got %h", $time, e.flags,
                   out_timeout_flags);
          err_cnt++;
        end
        if (out_irq !== e.irq) begin
          $display("%0t: irq expected %b got %b", $time, e.irq, out_irq);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state, then module on
    push_req(REQ_READ,  SEL_COUNT,  2'd0, '0);
    wait_idle();
    set_module_en(1'b1);

    push_req(REQ_WRITE, SEL_RELOAD, 2'd0, 32'd2);
    push_req(REQ_WRITE, SEL_RELOAD, 2'd1, '0);
    push_req(REQ_WRITE, SEL_RELOAD, 2'd3, 32'hFFFF_FFFF);
    push_req(REQ_WRITE, SEL_ENABLE, 2'd0, 32'd1);
    push_req(REQ_WRITE, SEL_ENABLE, 2'd1, 32'd1);
    push_req(REQ_WRITE, SEL_ENABLE, 2'd3, 32'hFFFF_FFFF);
    push_req(REQ_WRITE, SEL_ENABLE, 2'd1, 32'd1);       // already on: no reload
    push_req(REQ_WRITE, SEL_MASK,   2'd0, 32'hFFFF_FFF5);
    push_req(REQ_TICK,  SEL_STATUS, 2'd0, '0);
    push_req(REQ_TICK,  SEL_W'(7),  2'd3, 32'hFFFF_FFFF);
    push_req(REQ_TICK,  SEL_STATUS, 2'd0, '0);
    push_req(REQ_READ,  SEL_STATUS, 2'd0, '0);
    push_req(REQ_WRITE, SEL_COUNT,  2'd0, 32'h1234_5678); // read-only
    push_req(REQ_READ,  SEL_COUNT,  2'd0, '0);
    push_req(REQ_WRITE, SEL_RELOAD, 2'd0, 32'd5);       // deferred until next reload
    push_req(REQ_READ,  SEL_RELOAD, 2'd0, '0);
    push_req(REQ_WRITE, SEL_STATUS, 2'd0, 32'hFFFF_FFF1);
    push_req(REQ_WRITE, SEL_ENABLE, 2'd0, 32'hFFFF_FFFE); // off, count kept
    push_req(REQ_TICK,  SEL_STATUS, 2'd0, '0);
    push_req(REQ_READ,  SEL_COUNT,  2'd0, '0);
    push_req(REQ_READ,  SEL_COUNT,  2'd3, '0);
    push_req(REQ_READ,  SEL_ENABLE, 2'd3, '0);
    push_req(REQ_WRITE, SEL_W'(6),  2'd2, 32'hFFFF_FFFF); // unknown register
    push_req(REQ_READ,  SEL_W'(7),  2'd1, '0);
    push_req(REQ_UNKNOWN, SEL_MASK, 2'd0, 32'hFFFF_FFFF);
    wait_idle();

    push_random(300);
    wait_idle();
    set_module_en(1'b0);
    push_random(100);
    wait_idle();
    set_module_en(1'b1);
    push_random(200);
    wait_idle();
    push_random(225);
    wait_idle();

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
